// ----- sv/skps_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the scalar Kalman predictive smoother.
// Used by the divider, the datapath, the controller and the top level.
package skps_pkg;

	localparam int DATA_WIDTH_DEF = 32;

	// Fixed field widths.
	localparam int COV_W      = 32;  // covariance, Q8.24
	localparam int NOISE_W    = 25;  // process and measurement noise, Q1.24
	localparam int ALPHA_W    = 17;  // predict weight, Q1.16
	localparam int GAIN_W     = 25;  // gain K, Q1.24 up to one inclusive
	localparam int FUNC_W     = 2;
	localparam int HIST_W     = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int DIV_STEPS  = GAIN_W;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

	localparam logic [ALPHA_W-1:0] ONE_Q16 = ALPHA_W'(65536);
	localparam logic [GAIN_W-1:0]  ONE_Q24 = GAIN_W'(16777216);
	localparam logic [HIST_W-1:0]  HIST_FULL = HIST_W'(3);

	// Register reset values.
	localparam logic [NOISE_W-1:0] PROCESS_NOISE_RST = NOISE_W'(16777);
	localparam logic [NOISE_W-1:0] MEASURE_NOISE_RST = NOISE_W'(167772);
	localparam logic [COV_W-1:0]   INIT_COV_RST      = COV_W'(16777216);
	localparam logic [ALPHA_W-1:0] PREDICT_WEIGHT_RST = ALPHA_W'(45875);

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MEASURE_NOISE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_COVARIANCE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PREDICT_WEIGHT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CARRY_COV       = 3'd4;

	// Item functions.
	localparam logic [FUNC_W-1:0] FN_FILTER = 2'd0;
	localparam logic [FUNC_W-1:0] FN_SEED   = 2'd1;
	localparam logic [FUNC_W-1:0] FN_CLEAR  = 2'd2;

	// Multiply phases; each selects its own rounding.
	localparam logic [1:0] PH_BLEND = 2'd0;
	localparam logic [1:0] PH_GAIN  = 2'd1;
	localparam logic [1:0] PH_COV   = 2'd2;

	typedef struct packed {
		logic       capture;
		logic       pass;
		logic       load;
		logic       mul_lo;
		logic       mul_hi;
		logic       mul_sum;
		logic       fin_blend;
		logic       setup_k;
		logic       fin_res;
		logic       fin_cov;
		logic       emit;
		logic [1:0] phase;
	} dp_cmd_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              hist_full;
		logic              div_done;
		logic              out_free;
	} dp_sts_t;

endpackage

// ----- sv/skps_div.sv -----
`timescale 1ns / 1ps
// Restoring divider for the gain: quot = floor(dividend * 2^24 / divisor).
// One quotient bit per cycle; depends on skps_pkg.
module skps_div import skps_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [COV_W-1:0]   dividend,
	input  logic [COV_W:0]     divisor,
	output logic               done,
	output logic [GAIN_W-1:0]  quot
);

	logic                 busy_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [COV_W:0]       rem_q;
	logic [COV_W:0]       div_q;
	logic [GAIN_W-1:0]    bits_q;
	logic [GAIN_W-1:0]    quot_q;
	logic                 zero_q;
	logic [COV_W+1:0]     trial;
	logic                 fits;

	// The dividend never exceeds the divisor, so the quotient fits in the gain width
	// and the long division can start with the upper dividend bits already in place.
	assign trial = {rem_q, bits_q[GAIN_W-1]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= DIV_CNT_W'(DIV_STEPS - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= {2'b00, dividend[COV_W-1:1]};
			bits_q <= {dividend[0], {(GAIN_W-1){1'b0}}};
			div_q  <= divisor;
			zero_q <= divisor == '0;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= fits ? (COV_W+1)'(trial - {1'b0, div_q}) : trial[COV_W:0];
			bits_q <= {bits_q[GAIN_W-2:0], 1'b0};
			quot_q <= {quot_q[GAIN_W-2:0], fits};
		end
	end

	assign done = !busy_q;
	assign quot = zero_q ? '0 : quot_q;

endmodule

// ----- sv/skps_dp.sv -----
`timescale 1ns / 1ps
// Datapath of the smoother: registers, history, covariance, split multiplier,
// rounding, saturation and the output register. Uses skps_pkg and skps_div.
module skps_dp import skps_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data,
	input  logic [FUNC_W-1:0]            in_func,
	input  logic signed [DATA_WIDTH-1:0] in_sample,
	input  dp_cmd_t                      cmd,
	output dp_sts_t                      sts,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [DATA_WIDTH-1:0] out_smoothed,
	output logic [COV_W-1:0]             out_cov,
	output logic                         out_pass
);

	localparam int EW = DATA_WIDTH + 3;
	localparam int MW = (EW > COV_W) ? EW : COV_W;
	localparam int CW = (MW + 1) / 2;
	localparam int PW = CW + GAIN_W;
	localparam int AW = MW + GAIN_W;
	localparam logic [AW-1:0] HALF16 = AW'(1) << 15;
	localparam logic [AW-1:0] HALF24 = AW'(1) << 23;
	localparam logic signed [EW-1:0] SAT_HI = EW'({1'b0, {(DATA_WIDTH-1){1'b1}}});
	localparam logic signed [EW-1:0] SAT_LO = -SAT_HI - EW'(1);

	function automatic logic [MW-1:0] magnitude(input logic signed [EW-1:0] v);
		logic signed [EW-1:0] n;
		n = -v;
		return v[EW-1] ? MW'($unsigned(n)) : MW'($unsigned(v));
	endfunction

	// Configuration.
	logic [NOISE_W-1:0] q_noise_q;
	logic [NOISE_W-1:0] r_noise_q;
	logic [COV_W-1:0]   init_cov_q;
	logic [ALPHA_W-1:0] alpha_q;
	logic               carry_q;

	// State.
	logic signed [DATA_WIDTH-1:0] last_q;
	logic signed [DATA_WIDTH-1:0] prior_q;
	logic [HIST_W-1:0]            hist_q;
	logic [COV_W-1:0]             cov_q;

	// Working registers.
	logic [FUNC_W-1:0]            func_q;
	logic signed [DATA_WIDTH-1:0] sample_q;
	logic [MW-1:0]                mag_q;
	logic                         neg_q;
	logic [GAIN_W-1:0]            mulb_q;
	logic [PW-1:0]                pp_q;
	logic [AW-1:0]                acc_q;
	logic [COV_W-1:0]             p1_q;
	logic [GAIN_W-1:0]            k_q;
	logic signed [EW-1:0]         blend_q;
	logic signed [DATA_WIDTH-1:0] res_q;
	logic [COV_W-1:0]             rescov_q;
	logic                         respass_q;
	logic                         out_valid_q;

	logic [COV_W-1:0]             p_sel;
	logic [COV_W:0]               p_sum;
	logic [COV_W-1:0]             p1;
	logic [COV_W:0]               denom;
	logic signed [EW-1:0]         diff;
	logic signed [EW-1:0]         diff2;
	logic [ALPHA_W-1:0]           alpha_sat;
	logic [CW-1:0]                mul_a;
	logic [PW-1:0]                prod;
	logic [AW-1:0]                half;
	logic [EW-1:0]                rnd16;
	logic [EW-1:0]                rnd24;
	logic signed [EW-1:0]         sr16;
	logic signed [EW-1:0]         sr24;
	logic signed [EW-1:0]         res_wide;
	logic signed [DATA_WIDTH-1:0] res_sat;
	logic [COV_W-1:0]             cov_new;
	logic                         div_done;
	logic [GAIN_W-1:0]            div_quot;
	logic                         push_en;
	logic signed [DATA_WIDTH-1:0] push_val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_noise_q  <= PROCESS_NOISE_RST;
			r_noise_q  <= MEASURE_NOISE_RST;
			init_cov_q <= INIT_COV_RST;
			alpha_q    <= PREDICT_WEIGHT_RST;
			carry_q    <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PROCESS_NOISE:   q_noise_q  <= cfg_data[NOISE_W-1:0];
				REG_MEASURE_NOISE:   r_noise_q  <= cfg_data[NOISE_W-1:0];
				REG_INIT_COVARIANCE: init_cov_q <= cfg_data[COV_W-1:0];
				REG_PREDICT_WEIGHT:  alpha_q    <= cfg_data[ALPHA_W-1:0];
				REG_CARRY_COV:       carry_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign p_sel     = carry_q ? cov_q : init_cov_q;
	assign p_sum     = {1'b0, p_sel} + (COV_W+1)'(q_noise_q);
	assign p1        = p_sum[COV_W] ? '1 : p_sum[COV_W-1:0];
	assign denom     = {1'b0, p1} + (COV_W+1)'(r_noise_q);
	assign diff      = EW'(last_q) - EW'(prior_q);
	assign diff2     = EW'(sample_q) - blend_q;
	assign alpha_sat = (alpha_q > ONE_Q16) ? ONE_Q16 : alpha_q;

	// The magnitude is multiplied in two halves through one narrow multiplier.
	assign mul_a = cmd.mul_lo ? mag_q[CW-1:0] : CW'(mag_q[MW-1:CW]);
	assign prod  = PW'(mul_a) * PW'(mulb_q);

	always_comb begin
		case (cmd.phase)
			PH_BLEND: half = HALF16;
			PH_GAIN:  half = HALF24;
			default:  half = '0;
		endcase
	end

	// Half is added to the magnitude (half away from zero); PH_COV truncates.
	assign rnd16    = acc_q[EW+15:16];
	assign rnd24    = acc_q[EW+23:24];
	assign sr16     = neg_q ? -$signed(rnd16) : $signed(rnd16);
	assign sr24     = neg_q ? -$signed(rnd24) : $signed(rnd24);
	assign res_wide = blend_q + sr24;
	assign res_sat  = (res_wide > SAT_HI) ? DATA_WIDTH'(SAT_HI) :
		(res_wide < SAT_LO) ? DATA_WIDTH'(SAT_LO) : res_wide[DATA_WIDTH-1:0];
	assign cov_new  = acc_q[COV_W+23:24];

	skps_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.load),
		.dividend (p1),
		.divisor  (denom),
		.done     (div_done),
		.quot     (div_quot)
	);

	always_comb begin
		push_en  = 1'b0;
		push_val = sample_q;
		if (cmd.fin_cov) begin
			push_en  = 1'b1;
			push_val = res_q;
		end else if (cmd.pass && (func_q == FN_FILTER || func_q == FN_SEED)) begin
			push_en = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q  <= '0;
			prior_q <= '0;
			hist_q  <= '0;
			cov_q   <= INIT_COV_RST;
		end else begin
			if (push_en) begin
				prior_q <= last_q;
				last_q  <= push_val;
				hist_q  <= (hist_q == HIST_FULL) ? hist_q : hist_q + 1'b1;
			end
			if (cmd.fin_cov) begin
				cov_q <= cov_new;
			end else if (cmd.pass) begin
				case (func_q)
					FN_FILTER: cov_q <= p_sel;
					FN_CLEAR: begin
						cov_q   <= init_cov_q;
						last_q  <= '0;
						prior_q <= '0;
						hist_q  <= '0;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q   <= in_func;
			sample_q <= in_sample;
		end
		if (cmd.load) begin
			mag_q  <= magnitude(diff);
			neg_q  <= diff[EW-1];
			mulb_q <= GAIN_W'(alpha_sat);
			p1_q   <= p1;
		end
		if (cmd.mul_lo) begin
			pp_q <= prod;
		end
		if (cmd.mul_hi) begin
			pp_q  <= prod;
			acc_q <= AW'(pp_q) + half;
		end
		if (cmd.mul_sum) begin
			acc_q <= acc_q + (AW'(pp_q) << CW);
		end
		if (cmd.fin_blend) begin
			blend_q <= EW'(last_q) + sr16;
		end
		if (cmd.setup_k) begin
			k_q    <= (div_quot > ONE_Q24) ? ONE_Q24 : div_quot;
			mulb_q <= (div_quot > ONE_Q24) ? ONE_Q24 : div_quot;
			mag_q  <= magnitude(diff2);
			neg_q  <= diff2[EW-1];
		end
		if (cmd.fin_res) begin
			res_q  <= res_sat;
			mag_q  <= MW'(p1_q);
			neg_q  <= 1'b0;
			mulb_q <= ONE_Q24 - k_q;
		end
		if (cmd.fin_cov) begin
			rescov_q  <= cov_new;
			respass_q <= 1'b0;
		end
		if (cmd.pass) begin
			res_q     <= sample_q;
			respass_q <= 1'b1;
			case (func_q)
				FN_FILTER: rescov_q <= p_sel;
				FN_CLEAR:  rescov_q <= init_cov_q;
				default:   rescov_q <= cov_q;
			endcase
		end
		if (cmd.emit) begin
			out_smoothed <= res_q;
			out_cov      <= rescov_q;
			out_pass     <= respass_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid     = out_valid_q;
	assign sts.func      = func_q;
	assign sts.hist_full = hist_q == HIST_FULL;
	assign sts.div_done  = div_done;
	assign sts.out_free  = !out_valid_q || out_ready;

endmodule

// ----- sv/skps_ctrl.sv -----
`timescale 1ns / 1ps
// Controller of the smoother: sequences capture, multiply phases, the gain
// division and the result hand-off. Depends on skps_pkg.
module skps_ctrl import skps_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_DECIDE = 4'd1;
	localparam logic [3:0] ST_PASS   = 4'd2;
	localparam logic [3:0] ST_LOAD   = 4'd3;
	localparam logic [3:0] ST_MLO    = 4'd4;
	localparam logic [3:0] ST_MHI    = 4'd5;
	localparam logic [3:0] ST_MSUM   = 4'd6;
	localparam logic [3:0] ST_FBLEND = 4'd7;
	localparam logic [3:0] ST_WDIV   = 4'd8;
	localparam logic [3:0] ST_FRES   = 4'd9;
	localparam logic [3:0] ST_FCOV   = 4'd10;
	localparam logic [3:0] ST_OUT    = 4'd11;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic [1:0] phase_q;
	logic [1:0] phase_d;

	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				state_d = (sts.func == FN_FILTER && sts.hist_full) ? ST_LOAD : ST_PASS;
			end
			ST_PASS: begin
				cmd.pass = 1'b1;
				state_d  = ST_OUT;
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
				phase_d  = PH_BLEND;
				state_d  = ST_MLO;
			end
			ST_MLO: begin
				cmd.mul_lo = 1'b1;
				state_d    = ST_MHI;
			end
			ST_MHI: begin
				cmd.mul_hi = 1'b1;
				state_d    = ST_MSUM;
			end
			ST_MSUM: begin
				cmd.mul_sum = 1'b1;
				case (phase_q)
					PH_BLEND: state_d = ST_FBLEND;
					PH_GAIN:  state_d = ST_FRES;
					default:  state_d = ST_FCOV;
				endcase
			end
			ST_FBLEND: begin
				cmd.fin_blend = 1'b1;
				state_d       = ST_WDIV;
			end
			ST_WDIV: begin
				if (sts.div_done) begin
					cmd.setup_k = 1'b1;
					phase_d     = PH_GAIN;
					state_d     = ST_MLO;
				end
			end
			ST_FRES: begin
				cmd.fin_res = 1'b1;
				phase_d     = PH_COV;
				state_d     = ST_MLO;
			end
			ST_FCOV: begin
				cmd.fin_cov = 1'b1;
				state_d     = ST_OUT;
			end
			ST_OUT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		cmd.phase = phase_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_BLEND;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
		end
	end

	assign in_ready = state_q == ST_IDLE;

endmodule

// ----- sv/scalar_kalman_predictive_smoother.sv -----
`timescale 1ns / 1ps
// Top level of the scalar Kalman predictive smoother: controller plus datapath.
// Depends on skps_pkg, skps_ctrl, skps_dp and skps_div.
//
//  channel | signals                          | carries
//  --------+----------------------------------+-----------------------------------
//  input   | s_tvalid s_tready s_tdata s_tuser| sample; func
//  output  | m_tvalid m_tready m_tdata m_tuser| smoothed, covariance_out; passed
//  config  | cfg_valid cfg_ready cfg_index    | register index and write data
//          | cfg_data                         |
//
// A filtered item with full history starts the 25-step gain divider, runs the
// blend multiply meanwhile, then the gain and covariance split multiplies; every
// other item passes straight on. One item is in work at a time; the next transfer
// is taken while a finished result still waits in the output register. After reset
// the history is empty and the configuration registers hold their defaults.
module scalar_kalman_predictive_smoother import skps_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      s_tvalid,
	output logic                                      s_tready,
	input  logic [((DATA_WIDTH+7)/8)*8-1:0]           s_tdata,   // sample
	input  logic [FUNC_W-1:0]                         s_tuser,   // func
	output logic                                      m_tvalid,
	input  logic                                      m_tready,
	output logic [((DATA_WIDTH+COV_W+7)/8)*8-1:0]     m_tdata,   // smoothed, covariance_out
	output logic                                      m_tuser,   // passed_through
	input  logic                                      cfg_valid,
	output logic                                      cfg_ready,
	input  logic [CFG_IDX_W-1:0]                      cfg_index,
	input  logic [CFG_DATA_W-1:0]                     cfg_data
);

	localparam int M_TDW = ((DATA_WIDTH + COV_W + 7) / 8) * 8;

	dp_cmd_t                      cmd;
	dp_sts_t                      sts;
	logic signed [DATA_WIDTH-1:0] smoothed;
	logic [COV_W-1:0]             covariance_out;

	assign cfg_ready = 1'b1;

	skps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	skps_dp #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_func      (s_tuser),
		.in_sample    (s_tdata[DATA_WIDTH-1:0]),
		.cmd          (cmd),
		.sts          (sts),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_smoothed (smoothed),
		.out_cov      (covariance_out),
		.out_pass     (m_tuser)
	);

	assign m_tdata = M_TDW'({covariance_out, smoothed});

endmodule
